// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL file that checks its own behaviour.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Implication whose consequent is checked at the next clock edge.
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== hdl/bced_pkg.sv =====
// Types and constants of the button click event detector.
package bced_pkg;

    localparam int NUM_BUTTONS = 8;
    localparam int BTN_W       = 3;
    localparam int TICK_W      = 16;
    localparam int DEB_W       = 8;
    localparam int REP_W       = 4;
    localparam int EVT_W       = 3;
    localparam int FIRED_W     = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int LIMIT_W     = 16;
    localparam int CMP_W       = (TICK_W > LIMIT_W) ? TICK_W : LIMIT_W;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_PRESSED = 3'd1,
        PH_WAIT    = 3'd2,
        PH_AGAIN   = 3'd3,
        PH_LONG    = 3'd5
    } t_phase;

    typedef enum logic [EVT_W-1:0] {
        EV_NONE   = 3'd0,
        EV_DOWN   = 3'd1,
        EV_UP     = 3'd2,
        EV_REPEAT = 3'd3,
        EV_SINGLE = 3'd4,
        EV_DOUBLE = 3'd5,
        EV_LSTART = 3'd6,
        EV_LHOLD  = 3'd7
    } t_event;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_LEVELS  = 2'd0,
        CFG_DEBOUNCE_TICKS = 2'd1,
        CFG_SHORT_TICKS    = 2'd2,
        CFG_LONG_TICKS     = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        t_phase             phase;
        logic [TICK_W-1:0]  tick_count;
        logic [DEB_W-1:0]   debounce_count;
        logic               stable_level;
        logic [REP_W-1:0]   press_repeats;
        t_event             last_event;
    } t_btn_state;

    // State of a button that has not been written since reset.
    localparam t_btn_state BTN_RESET = '{
        phase:          PH_IDLE,
        tick_count:     '0,
        debounce_count: '0,
        stable_level:   1'b1,
        press_repeats:  '0,
        last_event:     EV_NONE
    };

    function automatic logic [FIRED_W-1:0] ev_bit(input t_event code);
        logic [FIRED_W-1:0] mask;
        mask = '0;
        if (code != EV_NONE) begin
            mask[EVT_W'(code) - EVT_W'(1)] = 1'b1;
        end
        return mask;
    endfunction

endpackage

// ===== hdl/button_click_event_detector_top.sv =====
// Top level of the button click event detector with its per-button state memory.
// A word is registered in stage one, then in the output register; either can be stalled.
// Throughput: one word per cycle unless the output stalls, set by the read-modify-write loop
// on the state memory, which a one-entry bypass closes for back-to-back words on one button.
// Reset clears the configuration to its defaults and the per-entry valid bits;
// an entry not yet written reads as the idle reset state, so no clearing pass runs.
module button_click_event_detector_top
    import bced_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,  // [0] pin_level
    input  logic [BTN_W-1:0]      s_axis_tuser,  // [2:0] button_index
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [15:0]           m_axis_tdata,  // [2:0] event_code, [9:3] fired_events,
                                                 // [13:10] repeat_count
    output logic [BTN_W-1:0]      m_axis_tuser   // [2:0] button_echo
);

    `include "assert_macros.svh"

    logic [7:0]         r_active_levels;
    logic [DEB_W-1:0]   r_debounce_ticks;
    logic [LIMIT_W-1:0] r_short_ticks;
    logic [LIMIT_W-1:0] r_long_ticks;

    t_btn_state         r_mem [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] r_valid;

    logic               r_s1_v;
    logic [BTN_W-1:0]   r_s1_idx;
    logic               r_s1_raw;
    t_btn_state         r_rd_q;
    logic               r_rd_vld;
    logic               r_byp_hit;
    t_btn_state         r_byp_data;

    logic               r_out_v;
    logic [BTN_W-1:0]   r_out_idx;
    t_event             r_out_event;
    logic [FIRED_W-1:0] r_out_fired;
    logic [REP_W-1:0]   r_out_reps;

    logic               in_acc;
    logic               s1_adv;
    logic               in_range;
    logic               act;
    logic               pressed;
    t_btn_state         cur;
    t_btn_state         n_state;
    logic [TICK_W-1:0]  tick1;
    logic [DEB_W-1:0]   deb1;
    logic               stable1;
    logic [REP_W-1:0]   reps_inc;
    t_phase             n_phase;
    t_event             n_event;
    logic [FIRED_W-1:0] n_fired;
    logic [TICK_W-1:0]  n_tick;
    logic [REP_W-1:0]   n_reps;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_levels  <= '0;
            r_debounce_ticks <= DEB_W'(3);
            r_short_ticks    <= LIMIT_W'(60);
            r_long_ticks     <= LIMIT_W'(200);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_ACTIVE_LEVELS:  r_active_levels  <= i_cfg_wdata[7:0];
                CFG_DEBOUNCE_TICKS: r_debounce_ticks <= i_cfg_wdata[DEB_W-1:0];
                CFG_SHORT_TICKS:    r_short_ticks    <= i_cfg_wdata[LIMIT_W-1:0];
                CFG_LONG_TICKS:     r_long_ticks     <= i_cfg_wdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign s1_adv        = r_s1_v && (!r_out_v || m_axis_tready);
    assign s_axis_tready = !r_s1_v || s1_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_range      = ({1'b0, r_s1_idx} < (BTN_W+1)'(NUM_BUTTONS));

    // Pipeline control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
            r_valid <= '0;
        end else begin
            if (in_acc) begin
                r_s1_v <= 1'b1;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
            if (s1_adv) begin
                r_out_v <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_v <= 1'b0;
            end
            if (s1_adv && in_range) begin
                r_valid[r_s1_idx] <= 1'b1;
            end
        end
    end

    // State memory: read on acceptance, written back as the word leaves stage one.
    always_ff @(posedge i_clk) begin
        if (s1_adv && in_range) begin
            r_mem[r_s1_idx] <= n_state;
        end
        if (in_acc) begin
            r_rd_q <= r_mem[s_axis_tuser];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_idx   <= s_axis_tuser;
            r_s1_raw   <= s_axis_tdata[0];
            r_rd_vld   <= r_valid[s_axis_tuser];
            r_byp_hit  <= s1_adv && in_range && (r_s1_idx == s_axis_tuser);
            r_byp_data <= n_state;
        end
    end

    always_comb begin
        if (r_byp_hit) begin
            cur = r_byp_data;
        end else if (r_rd_vld) begin
            cur = r_rd_q;
        end else begin
            cur = BTN_RESET;
        end
    end

    // Tick counting and debouncing ahead of the phase machine.
    always_comb begin
        act = r_active_levels[r_s1_idx];
        if ((cur.phase != PH_IDLE) && (cur.tick_count != {TICK_W{1'b1}})) begin
            tick1 = cur.tick_count + TICK_W'(1);
        end else begin
            tick1 = cur.tick_count;
        end
        stable1 = cur.stable_level;
        if (r_s1_raw != cur.stable_level) begin
            if (cur.debounce_count != {DEB_W{1'b1}}) begin
                deb1 = cur.debounce_count + DEB_W'(1);
            end else begin
                deb1 = cur.debounce_count;
            end
            if (deb1 >= r_debounce_ticks) begin
                stable1 = r_s1_raw;
                deb1    = '0;
            end
        end else begin
            deb1 = '0;
        end
        pressed = (stable1 == act);
        if (cur.press_repeats != {REP_W{1'b1}}) begin
            reps_inc = cur.press_repeats + REP_W'(1);
        end else begin
            reps_inc = cur.press_repeats;
        end
    end

    // Next phase, tick count and repeat count.
    always_comb begin
        n_phase = cur.phase;
        n_tick  = tick1;
        n_reps  = cur.press_repeats;
        unique case (cur.phase)
            PH_IDLE: begin
                if (pressed) begin
                    n_tick  = '0;
                    n_reps  = REP_W'(1);
                    n_phase = PH_PRESSED;
                end
            end
            PH_PRESSED: begin
                if (!pressed) begin
                    n_tick  = '0;
                    n_phase = PH_WAIT;
                end else if (CMP_W'(tick1) > CMP_W'(r_long_ticks)) begin
                    n_phase = PH_LONG;
                end
            end
            PH_WAIT: begin
                if (pressed) begin
                    n_reps  = reps_inc;
                    n_tick  = '0;
                    n_phase = PH_AGAIN;
                end else if (CMP_W'(tick1) > CMP_W'(r_short_ticks)) begin
                    n_phase = PH_IDLE;
                end
            end
            PH_AGAIN: begin
                if (!pressed) begin
                    if (CMP_W'(tick1) < CMP_W'(r_short_ticks)) begin
                        n_tick  = '0;
                        n_phase = PH_WAIT;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            PH_LONG: begin
                if (!pressed) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // Event code and fired mask.
    always_comb begin
        n_event = cur.last_event;
        n_fired = '0;
        unique case (cur.phase)
            PH_IDLE: begin
                if (pressed) begin
                    n_event = EV_DOWN;
                    n_fired = ev_bit(EV_DOWN);
                end else begin
                    n_event = EV_NONE;
                end
            end
            PH_PRESSED: begin
                if (!pressed) begin
                    n_event = EV_UP;
                    n_fired = ev_bit(EV_UP);
                end else if (CMP_W'(tick1) > CMP_W'(r_long_ticks)) begin
                    n_event = EV_LSTART;
                    n_fired = ev_bit(EV_LSTART);
                end
            end
            PH_WAIT: begin
                if (pressed) begin
                    n_event = EV_DOWN;
                    n_fired = ev_bit(EV_DOWN) | ev_bit(EV_REPEAT);
                    if (reps_inc == REP_W'(2)) begin
                        n_fired = n_fired | ev_bit(EV_DOUBLE);
                    end
                end else if (CMP_W'(tick1) > CMP_W'(r_short_ticks)) begin
                    if (cur.press_repeats == REP_W'(1)) begin
                        n_event = EV_SINGLE;
                        n_fired = ev_bit(EV_SINGLE);
                    end else if (cur.press_repeats == REP_W'(2)) begin
                        n_event = EV_DOUBLE;
                    end
                end
            end
            PH_AGAIN: begin
                if (!pressed) begin
                    n_event = EV_UP;
                    n_fired = ev_bit(EV_UP);
                end
            end
            PH_LONG: begin
                if (pressed) begin
                    n_event = EV_LHOLD;
                    n_fired = ev_bit(EV_LHOLD);
                end else begin
                    n_event = EV_UP;
                    n_fired = ev_bit(EV_UP);
                end
            end
            default: begin
                n_event = EV_NONE;
            end
        endcase
    end

    always_comb begin
        n_state.phase          = n_phase;
        n_state.tick_count     = n_tick;
        n_state.debounce_count = deb1;
        n_state.stable_level   = stable1;
        n_state.press_repeats  = n_reps;
        n_state.last_event     = n_event;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_idx <= r_s1_idx;
            if (in_range) begin
                r_out_event <= n_event;
                r_out_fired <= n_fired;
                r_out_reps  <= n_reps;
            end else begin
                r_out_event <= EV_NONE;
                r_out_fired <= '0;
                r_out_reps  <= '0;
            end
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tuser  = r_out_idx;
    assign m_axis_tdata  = {2'b00, r_out_reps, r_out_fired, r_out_event};

    `ASSERT_IMPL(a_fired_has_code, r_out_v && (r_out_fired != '0), r_out_event != EV_NONE,
        "A fired event left the event code at none.")
    `ASSERT_IMPL(a_fired_single,
        r_out_v, $onehot0(r_out_fired & ~(ev_bit(EV_REPEAT) | ev_bit(EV_DOUBLE))),
        "More than one primary event fired in one word.")
    `ASSERT_NEXT(a_stage_holds, r_s1_v && !s1_adv, r_s1_v && $stable(r_s1_idx),
        "Stage one lost or changed a stalled word.")

endmodule

// ===== test/tb_button_click_event_detector_top.sv =====
// Self-checking testbench of the button click event detector: directed and random button scans.
module tb_button_click_event_detector_top;
    import bced_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_OFF_CYCLES = 60;
    localparam int SAT_HOLD_WORDS  = 20;

    typedef struct packed {
        logic [BTN_W-1:0]   btn;
        t_event             ev;
        logic [FIRED_W-1:0] fired;
        logic [REP_W-1:0]   rep;
    } t_result;

    typedef struct packed {
        logic [BTN_W-1:0]   btn;
        logic               lvl;
        logic               typed;
        t_event             ev;
        logic [FIRED_W-1:0] fired;
        logic [REP_W-1:0]   rep;
    } t_row;

    localparam t_row PLAN [17] = '{
        '{3'd0, 1'b1, 1'b1, EV_NONE, 7'b0000000, 4'd0},
        '{3'd7, 1'b1, 1'b1, EV_NONE, 7'b0000000, 4'd0},
        '{3'd0, 1'b0, 1'b1, EV_NONE, 7'b0000000, 4'd0},
        '{3'd0, 1'b0, 1'b1, EV_NONE, 7'b0000000, 4'd0},
        '{3'd0, 1'b0, 1'b1, EV_DOWN, 7'b0000001, 4'd1},
        '{3'd0, 1'b1, 1'b1, EV_DOWN, 7'b0000000, 4'd1},
        '{3'd0, 1'b1, 1'b1, EV_DOWN, 7'b0000000, 4'd1},
        '{3'd0, 1'b1, 1'b1, EV_UP,   7'b0000010, 4'd1},
        '{3'd0, 1'b0, 1'b1, EV_UP,   7'b0000000, 4'd1},
        '{3'd0, 1'b0, 1'b1, EV_UP,   7'b0000000, 4'd1},
        '{3'd0, 1'b0, 1'b1, EV_DOWN, 7'b0010101, 4'd2},
        '{3'd0, 1'b1, 1'b0, EV_NONE, 7'b0000000, 4'd0},
        '{3'd0, 1'b1, 1'b0, EV_NONE, 7'b0000000, 4'd0},
        '{3'd0, 1'b1, 1'b0, EV_NONE, 7'b0000000, 4'd0},
        '{3'd7, 1'b0, 1'b0, EV_NONE, 7'b0000000, 4'd0},
        '{3'd7, 1'b0, 1'b0, EV_NONE, 7'b0000000, 4'd0},
        '{3'd7, 1'b0, 1'b0, EV_NONE, 7'b0000000, 4'd0}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;
    logic [BTN_W-1:0]      s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [15:0]           m_axis_tdata;
    logic [BTN_W-1:0]      m_axis_tuser;

    logic [7:0]         cfg_active   = 8'h00;
    logic [7:0]         cfg_debounce = 8'd3;
    logic [LIMIT_W-1:0] cfg_short    = 16'd60;
    logic [LIMIT_W-1:0] cfg_long     = 16'd200;

    t_phase              btn_phase  [NUM_BUTTONS];
    logic [TICK_W-1:0]   btn_ticks  [NUM_BUTTONS];
    logic [DEB_W-1:0]    btn_deb    [NUM_BUTTONS];
    logic                btn_stable [NUM_BUTTONS];
    logic [REP_W-1:0]    btn_reps   [NUM_BUTTONS];
    t_event              btn_last   [NUM_BUTTONS];

    t_result expected_results [$];
    t_row    pending_row;
    int      words_sent       = 0;
    int      results_checked  = 0;
    int      mismatches       = 0;
    bit      no_gaps_tx       = 1'b0;
    bit      rx_steady        = 1'b0;
    bit      hold_off_request = 1'b0;

    button_click_event_detector_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            btn_phase[b]  = PH_IDLE;
            btn_ticks[b]  = '0;
            btn_deb[b]    = '0;
            btn_stable[b] = ~cfg_active[b];
            btn_reps[b]   = '0;
            btn_last[b]   = EV_NONE;
        end
    end

    function automatic logic [FIRED_W-1:0] flag_of(input t_event code);
        return FIRED_W'(1) << (int'(code) - 1);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic int span(input int limit);
        return (limit > 40) ? 40 : limit;
    endfunction

    task automatic advance_button(input logic [BTN_W-1:0] b, input logic raw,
                                  output t_result res);
        logic               act;
        logic               pressed;
        logic [FIRED_W-1:0] fired;
        fired = '0;
        act = cfg_active[b];
        if (btn_phase[b] != PH_IDLE && btn_ticks[b] != '1) begin
            btn_ticks[b] = btn_ticks[b] + TICK_W'(1);
        end
        if (raw != btn_stable[b]) begin
            if (btn_deb[b] != '1) begin
                btn_deb[b] = btn_deb[b] + DEB_W'(1);
            end
            if (btn_deb[b] >= cfg_debounce) begin
                btn_stable[b] = raw;
                btn_deb[b]    = '0;
            end
        end else begin
            btn_deb[b] = '0;
        end
        pressed = (btn_stable[b] == act);
        case (btn_phase[b])
            PH_IDLE: begin
                if (pressed) begin
                    btn_last[b]  = EV_DOWN;
                    fired        = fired | flag_of(EV_DOWN);
                    btn_ticks[b] = '0;
                    btn_reps[b]  = 4'd1;
                    btn_phase[b] = PH_PRESSED;
                end else begin
                    btn_last[b] = EV_NONE;
                end
            end
            PH_PRESSED: begin
                if (!pressed) begin
                    btn_last[b]  = EV_UP;
                    fired        = fired | flag_of(EV_UP);
                    btn_ticks[b] = '0;
                    btn_phase[b] = PH_WAIT;
                end else if (btn_ticks[b] > cfg_long) begin
                    btn_last[b]  = EV_LSTART;
                    fired        = fired | flag_of(EV_LSTART);
                    btn_phase[b] = PH_LONG;
                end
            end
            PH_WAIT: begin
                if (pressed) begin
                    btn_last[b] = EV_DOWN;
                    fired       = fired | flag_of(EV_DOWN);
                    if (btn_reps[b] != '1) begin
                        btn_reps[b] = btn_reps[b] + REP_W'(1);
                    end
                    if (btn_reps[b] == 4'd2) begin
                        fired = fired | flag_of(EV_DOUBLE);
                    end
                    fired        = fired | flag_of(EV_REPEAT);
                    btn_ticks[b] = '0;
                    btn_phase[b] = PH_AGAIN;
                end else if (btn_ticks[b] > cfg_short) begin
                    if (btn_reps[b] == 4'd1) begin
                        btn_last[b] = EV_SINGLE;
                        fired       = fired | flag_of(EV_SINGLE);
                    end else if (btn_reps[b] == 4'd2) begin
                        btn_last[b] = EV_DOUBLE;
                    end
                    btn_phase[b] = PH_IDLE;
                end
            end
            PH_AGAIN: begin
                if (!pressed) begin
                    btn_last[b] = EV_UP;
                    fired       = fired | flag_of(EV_UP);
                    if (btn_ticks[b] < cfg_short) begin
                        btn_ticks[b] = '0;
                        btn_phase[b] = PH_WAIT;
                    end else begin
                        btn_phase[b] = PH_IDLE;
                    end
                end
            end
            PH_LONG: begin
                if (pressed) begin
                    btn_last[b] = EV_LHOLD;
                    fired       = fired | flag_of(EV_LHOLD);
                end else begin
                    btn_last[b]  = EV_UP;
                    fired        = fired | flag_of(EV_UP);
                    btn_phase[b] = PH_IDLE;
                end
            end
            default: begin
                btn_phase[b] = PH_IDLE;
                btn_last[b]  = EV_NONE;
            end
        endcase
        res.btn   = b;
        res.ev    = btn_last[b];
        res.fired = fired;
        res.rep   = btn_reps[b];
    endtask

    task automatic report(input string what, input t_result want, input t_result got);
        mismatches++;
        if (mismatches <= 10) begin
            $write("%s: expected btn %0d event %0d fired %b repeats %0d, ",
                   what, want.btn, want.ev, want.fired, want.rep);
            $display("got btn %0d event %0d fired %b repeats %0d",
                     got.btn, got.ev, got.fired, got.rep);
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        t_result pred;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.btn   = m_axis_tuser;
                got.ev    = t_event'(m_axis_tdata[2:0]);
                got.fired = m_axis_tdata[9:3];
                got.rep   = m_axis_tdata[13:10];
                results_checked++;
                if (expected_results.size() == 0) begin
                    report("unexpected word", '0, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        report("mismatch", want, got);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                advance_button(s_axis_tuser, s_axis_tdata[0], pred);
                if (pending_row.typed) begin
                    pred.ev    = pending_row.ev;
                    pred.fired = pending_row.fired;
                    pred.rep   = pending_row.rep;
                end
                expected_results.push_back(pred);
            end
        end
    end

    initial begin
        int run;
        forever begin
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                m_axis_tready <= 1'b0;
                run = HOLD_OFF_CYCLES;
            end else if (rx_steady || $urandom_range(0, 3) != 0) begin
                m_axis_tready <= 1'b1;
                run = rx_steady ? 1 : $urandom_range(1, 16);
            end else begin
                m_axis_tready <= 1'b0;
                run = pick_gap() + 1;
            end
            repeat (run) @(posedge i_clk);
        end
    end

    task automatic offer(input t_row row);
        int gap;
        gap = no_gaps_tx ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, row.lvl};
        s_axis_tuser  <= row.btn;
        pending_row   <= row;
        do @(posedge i_clk); while (!s_axis_tready);
        words_sent++;
    endtask

    task automatic offer_level(input logic [BTN_W-1:0] b, input logic lvl);
        t_row row;
        row       = '0;
        row.btn   = b;
        row.lvl   = lvl;
        row.typed = 1'b0;
        offer(row);
    endtask

    task automatic scan_word(input logic [BTN_W-1:0] b, input logic lvl);
        if ($urandom_range(0, 5) == 0) begin
            offer_level(b ^ BTN_W'($urandom_range(1, 7)), 1'($urandom_range(0, 1)));
        end
        offer_level(b, lvl);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (results_checked != words_sent) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        case (idx)
            CFG_ACTIVE_LEVELS:  cfg_active   = value[7:0];
            CFG_DEBOUNCE_TICKS: cfg_debounce = value[7:0];
            CFG_SHORT_TICKS:    cfg_short    = value;
            CFG_LONG_TICKS:     cfg_long     = value;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [7:0] act, input logic [7:0] deb,
                              input logic [15:0] short_lim, input logic [15:0] long_lim);
        cfg_write(CFG_ACTIVE_LEVELS, 16'(act));
        cfg_write(CFG_DEBOUNCE_TICKS, 16'(deb));
        cfg_write(CFG_SHORT_TICKS, short_lim);
        cfg_write(CFG_LONG_TICKS, long_lim);
    endtask

    task automatic play_clicks(input logic [BTN_W-1:0] b);
        int   hold;
        int   rest;
        logic act;
        act = cfg_active[b];
        repeat ($urandom_range(1, 3)) begin
            hold = int'(cfg_debounce) + $urandom_range(0, span(int'(cfg_long)) + 3);
            rest = int'(cfg_debounce) + $urandom_range(0, span(int'(cfg_short)) + 3);
            repeat (hold) scan_word(b, act);
            repeat (rest) scan_word(b, ~act);
        end
    endtask

    task automatic run_phase(input int budget);
        int               start;
        int               pick;
        logic [BTN_W-1:0] b;
        logic             act;
        start = words_sent;
        while (words_sent - start < budget) begin
            pick = $urandom_range(0, 9);
            b    = BTN_W'($urandom_range(0, 7));
            act  = cfg_active[b];
            if (pick < 7) begin
                play_clicks(b);
            end else if (pick < 9) begin
                repeat ($urandom_range(1, 4)) begin
                    offer_level(BTN_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
                end
            end else begin
                repeat ($urandom_range(1, (cfg_debounce > 1) ? int'(cfg_debounce) - 1 : 1)) begin
                    offer_level(b, act);
                end
                repeat (int'(cfg_debounce) + 2) offer_level(b, ~act);
            end
        end
        settle();
    endtask

    // Drives one button into a long click run and a short hold, so that the
    // repeat count reaches its limit.
    task automatic saturate_counters();
        logic [BTN_W-1:0] b;
        logic             act;
        b = 3'd3;
        cfg_write(CFG_DEBOUNCE_TICKS, 16'd1);
        cfg_write(CFG_SHORT_TICKS, 16'd0);
        act = cfg_active[b];
        repeat (4) offer_level(b, ~act);
        settle();
        cfg_write(CFG_SHORT_TICKS, 16'hFFFF);
        cfg_write(CFG_LONG_TICKS, 16'hFFFF);
        repeat (17) begin
            offer_level(b, act);
            offer_level(b, ~act);
        end
        no_gaps_tx = 1'b1;
        rx_steady  = 1'b1;
        repeat (SAT_HOLD_WORDS) offer_level(b, act);
        repeat (3) offer_level(b, ~act);
        no_gaps_tx = 1'b0;
        rx_steady  = 1'b0;
        settle();
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_ACTIVE_LEVELS;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        pending_row   <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        for (int i = 0; i < 17; i++) begin
            offer(PLAN[i]);
        end
        settle();
        run_phase(40);

        // Active levels are rewritten without a reset; the stable levels stay as they were.
        set_config(8'hA5, 8'd0, 16'd0, 16'd0);
        run_phase(40);

        set_config(8'hFF, 8'd5, 16'hFFFF, 16'hFFFF);
        run_phase(20);

        set_config(8'h00, 8'd1, 16'd8, 16'd20);
        hold_off_request = 1'b1;
        no_gaps_tx       = 1'b1;
        repeat (40) offer_level(BTN_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
        no_gaps_tx = 1'b0;
        run_phase(40);

        set_config(8'($urandom_range(0, 255)), 8'd2, 16'd30, 16'd60);
        run_phase(40);

        saturate_counters();

        repeat (5) @(posedge i_clk);
        mismatches = mismatches + expected_results.size();
        $display("Sent %0d input words under six register settings, with stalls on both sides",
                 words_sent);
        $display("and a click run that saturates the repeat count; %0d results, %0d failures.",
                 results_checked, mismatches);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #12_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
